/* hw/rtl/gbn_pkg.sv */
// gbn_pkg: shared types, constants and sequence helpers for the go-back-n link controller
// used by gbn_ctrl, gbn_dp and the top level; depends on nothing else
package gbn_pkg;

	localparam int SEQ_W = 5;
	localparam int LEN_W = 9;
	localparam int MAX_RESULTS = 32;
	localparam int RES_AW = $clog2(MAX_RESULTS);
	localparam int CNT_W = RES_AW + 1;

	localparam logic [SEQ_W-1:0] MAX_SEQ = SEQ_W'(31);
	localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(5);
	localparam logic [LEN_W-1:0] FRAME_OVERHEAD = LEN_W'(7);

	localparam logic [2:0] REQ_PKT = 3'd0;
	localparam logic [2:0] REQ_LINK = 3'd1;
	localparam logic [2:0] REQ_FRAME = 3'd2;
	localparam logic [2:0] REQ_DATA_TMO = 3'd3;
	localparam logic [2:0] REQ_ACK_TMO = 3'd4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK = 2'd1;
	localparam logic [1:0] KIND_NAK = 2'd2;

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_DATA = 3'd1,
		ACT_ACK = 3'd2,
		ACT_NAK = 3'd3,
		ACT_DELIVER = 3'd4,
		ACT_RELEASE = 3'd5
	} action_t;

	typedef struct packed {
		action_t action;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] ack;
		logic [LEN_W-1:0] len;
	} res_entry_t;

	typedef enum logic [3:0] {
		OP_IDLE = 4'd0,
		OP_PKT = 4'd1,
		OP_LINK = 4'd2,
		OP_NAK = 4'd3,
		OP_ACK = 4'd4,
		OP_REL = 4'd5,
		OP_DELIVER = 4'd6,
		OP_GB_TMO = 4'd7,
		OP_GB_NAK = 4'd8,
		OP_RESEND = 4'd9,
		OP_FILL_NONE = 4'd10,
		OP_DRAIN = 4'd11
	} dp_op_t;

	typedef struct packed {
		logic load;
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic [1:0] kind;
		logic bad_frame;
		logic nak_sent;
		logic win_full;
		logic rel_ok;
		logic seq_eq;
		logic seq_gt;
		logic nak_ok;
		logic resend_more;
		logic cnt_zero;
		logic drain_last;
	} dp_status_t;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] k);
		return (k < MAX_SEQ) ? k + SEQ_W'(1) : '0;
	endfunction

	// b lies in the circular window [a, c)
	function automatic logic in_window(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
			input logic [SEQ_W-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

endpackage

/* hw/rtl/gbn_ram.sv */
// gbn_ram: generic single-write, single-read ram with registered read data
// stand-alone, no package needed
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/gbn_ctrl.sv */
// gbn_ctrl: sequencing state machine of the link controller
// depends on gbn_pkg; drives gbn_dp through ctrl_cmd_t and reads dp_status_t
module gbn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gbn_pkg::dp_status_t status,
	output gbn_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_EVAL = 7'b0000010,
		ST_REL = 7'b0000100,
		ST_POST = 7'b0001000,
		ST_RESEND = 7'b0010000,
		ST_FIN = 7'b0100000,
		ST_DRAIN = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.op = gbn_pkg::OP_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_FIN;
				unique case (status.req)
					gbn_pkg::REQ_PKT: begin
						if (!status.win_full) cmd.op = gbn_pkg::OP_PKT;
					end
					gbn_pkg::REQ_LINK: cmd.op = gbn_pkg::OP_LINK;
					gbn_pkg::REQ_FRAME: begin
						if (status.bad_frame) begin
							if (!status.nak_sent) cmd.op = gbn_pkg::OP_NAK;
						end else begin
							state_d = ST_REL;
						end
					end
					gbn_pkg::REQ_DATA_TMO: begin
						cmd.op = gbn_pkg::OP_GB_TMO;
						state_d = ST_RESEND;
					end
					gbn_pkg::REQ_ACK_TMO: cmd.op = gbn_pkg::OP_ACK;
					default: cmd.op = gbn_pkg::OP_IDLE;
				endcase
			end
			ST_REL: begin
				// one acknowledged frame released per cycle
				if (status.rel_ok) begin
					cmd.op = gbn_pkg::OP_REL;
				end else begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				state_d = ST_FIN;
				if (status.kind == gbn_pkg::KIND_DATA) begin
					if (status.seq_eq) begin
						cmd.op = gbn_pkg::OP_DELIVER;
					end else if (status.seq_gt && !status.nak_sent) begin
						cmd.op = gbn_pkg::OP_NAK;
					end
				end else if (status.kind == gbn_pkg::KIND_NAK) begin
					if (status.nak_ok) begin
						cmd.op = gbn_pkg::OP_GB_NAK;
						state_d = ST_RESEND;
					end
				end
			end
			ST_RESEND: begin
				if (status.resend_more) begin
					cmd.op = gbn_pkg::OP_RESEND;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (status.cnt_zero) cmd.op = gbn_pkg::OP_FILL_NONE;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				cmd.op = gbn_pkg::OP_DRAIN;
				if (status.drain_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/gbn_dp.sv */
// gbn_dp: link state registers, result buffer and output stage
// depends on gbn_pkg and gbn_ram; commanded by gbn_ctrl
module gbn_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gbn_pkg::ctrl_cmd_t               cmd,
	output gbn_pkg::dp_status_t              status,
	input  logic [2:0]                       req_type,
	input  logic [1:0]                       frame_kind,
	input  logic [gbn_pkg::SEQ_W-1:0]        frame_seq,
	input  logic [gbn_pkg::SEQ_W-1:0]        peer_ack,
	input  logic [gbn_pkg::LEN_W-1:0]        frame_len,
	input  logic                             crc_ok,
	output logic                             strobe,
	output logic [2:0]                       action,
	output logic [gbn_pkg::SEQ_W-1:0]        seq_num,
	output logic [gbn_pkg::SEQ_W-1:0]        ack_num,
	output logic [gbn_pkg::LEN_W-1:0]        deliver_len,
	output logic                             start_data_timer,
	output logic                             ack_timer_start,
	output logic                             ack_timer_stop,
	output logic                             network_enable,
	output logic                             last
);

	localparam int EW = $bits(gbn_pkg::res_entry_t);

	// latched event
	logic [2:0] req_q;
	logic [1:0] kind_q;
	logic [gbn_pkg::SEQ_W-1:0] fseq_q, fack_q;
	logic [gbn_pkg::LEN_W-1:0] flen_q;
	logic crc_q;

	// link state
	logic [gbn_pkg::SEQ_W-1:0] next_q, oldest_q, expected_q, outstanding_q, idx_q;
	logic link_q, nak_q;

	logic [gbn_pkg::CNT_W-1:0] wcount_q;
	logic [gbn_pkg::RES_AW-1:0] rptr_q;
	logic strobe_q, last_q, en_q;

	logic [gbn_pkg::SEQ_W-1:0] ack_val, nak_from;
	logic [gbn_pkg::LEN_W-1:0] dlen;
	logic wr_req, wr_en, net_en;
	gbn_pkg::res_entry_t wentry, rentry;
	logic [EW-1:0] rdata;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			kind_q <= frame_kind;
			fseq_q <= frame_seq;
			fack_q <= peer_ack;
			flen_q <= frame_len;
			crc_q <= crc_ok;
		end
	end

	assign ack_val = (expected_q == '0) ? gbn_pkg::MAX_SEQ : expected_q - gbn_pkg::SEQ_W'(1);
	assign nak_from = gbn_pkg::seq_inc(fack_q);
	assign dlen = (flen_q > gbn_pkg::FRAME_OVERHEAD) ? flen_q - gbn_pkg::FRAME_OVERHEAD : '0;
	assign net_en = (outstanding_q < gbn_pkg::MAX_SEQ) && link_q;

	always_comb begin
		wr_req = 1'b1;
		wentry.action = gbn_pkg::ACT_NONE;
		wentry.seq = '0;
		wentry.ack = '0;
		wentry.len = '0;
		unique case (cmd.op)
			gbn_pkg::OP_PKT, gbn_pkg::OP_RESEND: begin
				wentry.action = gbn_pkg::ACT_DATA;
				wentry.seq = next_q;
				wentry.ack = ack_val;
			end
			gbn_pkg::OP_NAK: begin
				wentry.action = gbn_pkg::ACT_NAK;
				wentry.ack = ack_val;
			end
			gbn_pkg::OP_ACK: begin
				wentry.action = gbn_pkg::ACT_ACK;
				wentry.ack = ack_val;
			end
			gbn_pkg::OP_REL: begin
				wentry.action = gbn_pkg::ACT_RELEASE;
				wentry.seq = oldest_q;
			end
			gbn_pkg::OP_DELIVER: begin
				wentry.action = gbn_pkg::ACT_DELIVER;
				wentry.len = dlen;
			end
			gbn_pkg::OP_FILL_NONE: wr_req = 1'b1;
			default: wr_req = 1'b0;
		endcase
	end

	// results past the buffer depth are dropped, state still advances
	assign wr_en = wr_req && (wcount_q < gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			oldest_q <= '0;
			expected_q <= '0;
			outstanding_q <= '0;
			link_q <= 1'b0;
			nak_q <= 1'b0;
			idx_q <= '0;
			wcount_q <= '0;
			rptr_q <= '0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
			en_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.op == gbn_pkg::OP_DRAIN);
			last_q <= status.drain_last;
			en_q <= net_en;
			if (cmd.load) begin
				wcount_q <= '0;
				rptr_q <= '0;
			end
			if (wr_en) wcount_q <= wcount_q + gbn_pkg::CNT_W'(1);
			unique case (cmd.op)
				gbn_pkg::OP_PKT: begin
					outstanding_q <= outstanding_q + gbn_pkg::SEQ_W'(1);
					next_q <= gbn_pkg::seq_inc(next_q);
					link_q <= 1'b0;
				end
				gbn_pkg::OP_LINK: link_q <= 1'b1;
				gbn_pkg::OP_NAK: begin
					nak_q <= 1'b1;
					link_q <= 1'b0;
				end
				gbn_pkg::OP_ACK: link_q <= 1'b0;
				gbn_pkg::OP_REL: begin
					outstanding_q <= outstanding_q - gbn_pkg::SEQ_W'(1);
					oldest_q <= gbn_pkg::seq_inc(oldest_q);
				end
				gbn_pkg::OP_DELIVER: begin
					nak_q <= 1'b0;
					expected_q <= gbn_pkg::seq_inc(expected_q);
				end
				gbn_pkg::OP_GB_TMO: begin
					next_q <= oldest_q;
					idx_q <= '0;
				end
				gbn_pkg::OP_GB_NAK: begin
					next_q <= nak_from;
					idx_q <= '0;
				end
				gbn_pkg::OP_RESEND: begin
					next_q <= gbn_pkg::seq_inc(next_q);
					idx_q <= idx_q + gbn_pkg::SEQ_W'(1);
					link_q <= 1'b0;
				end
				gbn_pkg::OP_DRAIN: rptr_q <= rptr_q + gbn_pkg::RES_AW'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	gbn_ram #(
		.WIDTH(EW),
		.DEPTH(gbn_pkg::MAX_RESULTS)
	) u_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wcount_q[gbn_pkg::RES_AW-1:0]),
		.wdata(wentry),
		.raddr(rptr_q),
		.rdata(rdata)
	);

	always_comb begin
		status.req = req_q;
		status.kind = kind_q;
		status.bad_frame = (flen_q < gbn_pkg::MIN_FRAME_LEN) || !crc_q
			|| (fack_q > gbn_pkg::MAX_SEQ)
			|| ((kind_q == gbn_pkg::KIND_DATA) && (fseq_q > gbn_pkg::MAX_SEQ));
		status.nak_sent = nak_q;
		status.win_full = (outstanding_q >= gbn_pkg::MAX_SEQ);
		status.rel_ok = (outstanding_q != '0) && gbn_pkg::in_window(oldest_q, fack_q, next_q);
		status.seq_eq = (fseq_q == expected_q);
		status.seq_gt = (fseq_q > expected_q);
		status.nak_ok = gbn_pkg::in_window(oldest_q, nak_from, next_q);
		status.resend_more = (idx_q < outstanding_q);
		status.cnt_zero = (wcount_q == '0);
		status.drain_last = ({1'b0, rptr_q} == (wcount_q - gbn_pkg::CNT_W'(1)));
	end

	assign rentry = gbn_pkg::res_entry_t'(rdata);
	assign strobe = strobe_q;
	assign action = rentry.action;
	assign seq_num = rentry.seq;
	assign ack_num = rentry.ack;
	assign deliver_len = rentry.len;
	assign start_data_timer = (rentry.action == gbn_pkg::ACT_DATA);
	assign ack_timer_start = (rentry.action == gbn_pkg::ACT_DELIVER);
	assign ack_timer_stop = (rentry.action == gbn_pkg::ACT_DATA)
		|| (rentry.action == gbn_pkg::ACT_ACK) || (rentry.action == gbn_pkg::ACT_NAK);
	assign network_enable = en_q;
	assign last = last_q;

endmodule

/* hw/rtl/go_back_n_nak_link_controller.sv */
// go_back_n_nak_link_controller: top level; a work phase writes the commands of an event,
// one per cycle, into a 32-entry buffer, then a drain phase issues one result per cycle
// steps: evaluate; a good frame releases each acknowledged frame, then may deliver or nak;
// a valid nak or data timeout resends outstanding frames; an empty buffer gets a none entry
// busy falls as the last result shows, so the next transaction can start there; no stalls
// arst_n clears the window pointers, counts and flags; the result buffer is not cleared
module go_back_n_nak_link_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                req_type,
	input  logic [1:0]                frame_kind,
	input  logic [gbn_pkg::SEQ_W-1:0] frame_seq,
	input  logic [gbn_pkg::SEQ_W-1:0] peer_ack,
	input  logic [gbn_pkg::LEN_W-1:0] frame_len,
	input  logic                      crc_ok,
	output logic                      strobe,
	output logic [2:0]                action,
	output logic [gbn_pkg::SEQ_W-1:0] seq_num,
	output logic [gbn_pkg::SEQ_W-1:0] ack_num,
	output logic [gbn_pkg::LEN_W-1:0] deliver_len,
	output logic                      start_data_timer,
	output logic                      ack_timer_start,
	output logic                      ack_timer_stop,
	output logic                      network_enable,
	output logic                      last
);

	gbn_pkg::ctrl_cmd_t cmd;
	gbn_pkg::dp_status_t status;

	gbn_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.status(status),
		.cmd   (cmd)
	);

	gbn_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.req_type        (req_type),
		.frame_kind      (frame_kind),
		.frame_seq       (frame_seq),
		.peer_ack        (peer_ack),
		.frame_len       (frame_len),
		.crc_ok          (crc_ok),
		.strobe          (strobe),
		.action          (action),
		.seq_num         (seq_num),
		.ack_num         (ack_num),
		.deliver_len     (deliver_len),
		.start_data_timer(start_data_timer),
		.ack_timer_start (ack_timer_start),
		.ack_timer_stop  (ack_timer_stop),
		.network_enable  (network_enable),
		.last            (last)
	);

endmodule

/* hw/rtl/gbn_checker.sv */
// gbn_checker: port-level assertions for the go-back-n link controller, bound to the top
// depends only on the top level's ports
module gbn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic network_enable,
	input logic last
);

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	// results of one event come out back to back
	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a result run");

	// only the final result may show while the block is idle
	a_busy_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("block idle before final result");

	// network enable is one value across an event's results
	a_enable_steady: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> $stable(network_enable))
		else $error("network_enable changed within a result run");

	// a fresh event never has a result in the cycle right after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("result right after acceptance");

endmodule

bind go_back_n_nak_link_controller gbn_checker u_gbn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.network_enable(network_enable),
	.last          (last)
);

/* sim/testbench.sv */
// testbench for go_back_n_nak_link_controller: drives link events, predicts the command
// stream in a scoreboard class and checks every strobed command field by field
// depends on gbn_pkg and the controller rtl only
`timescale 1ns / 1ps

import gbn_pkg::*;

typedef struct {
	action_t action;
	logic [SEQ_W-1:0] seq;
	logic [SEQ_W-1:0] ack;
	logic [LEN_W-1:0] len;
	logic sdt;
	logic sat;
	logic stat;
	logic net_en;
	logic last;
} link_cmd_t;

class link_cmd_model;
	bit [SEQ_W-1:0] nts;
	bit [SEQ_W-1:0] oldest;
	bit [SEQ_W-1:0] exp_seq;
	bit [SEQ_W-1:0] outst;
	bit ready;
	bit nak_out;
	link_cmd_t ev[$];
	link_cmd_t pending[$];
	int events;
	int checked;
	int mismatches;
	int strays;
	int most_cmds;
	int full_hits;

	function bit [SEQ_W-1:0] seq_next(bit [SEQ_W-1:0] k);
		return (k == MAX_SEQ) ? '0 : k + 1'b1;
	endfunction

	// x within the circular span [lo, hi)
	function bit in_span(bit [SEQ_W-1:0] lo, bit [SEQ_W-1:0] x, bit [SEQ_W-1:0] hi);
		if (lo <= hi)
			return (lo <= x) && (x < hi);
		return (x >= lo) || (x < hi);
	endfunction

	function bit [SEQ_W-1:0] ack_val();
		return SEQ_W'((int'(exp_seq) + int'(MAX_SEQ)) % (int'(MAX_SEQ) + 1));
	endfunction

	function void add_cmd(action_t a, bit [SEQ_W-1:0] s, bit [SEQ_W-1:0] k,
			bit [LEN_W-1:0] d, bit sdt, bit sat, bit stat);
		link_cmd_t c;
		if (ev.size() >= MAX_RESULTS)
			return;
		c.action = a;
		c.seq = s;
		c.ack = k;
		c.len = d;
		c.sdt = sdt;
		c.sat = sat;
		c.stat = stat;
		c.net_en = 1'b0;
		c.last = 1'b0;
		ev.push_back(c);
	endfunction

	function void push_data(bit [SEQ_W-1:0] s);
		add_cmd(ACT_DATA, s, ack_val(), '0, 1'b1, 1'b0, 1'b1);
		ready = 1'b0;
	endfunction

	function void send_ctrl(action_t a);
		add_cmd(a, '0, ack_val(), '0, 1'b0, 1'b0, 1'b1);
		ready = 1'b0;
	endfunction

	function void nak_once();
		if (!nak_out) begin
			send_ctrl(ACT_NAK);
			nak_out = 1'b1;
		end
	endfunction

	function void resend_all();
		for (int i = 0; i < int'(outst); i++) begin
			push_data(nts);
			nts = seq_next(nts);
		end
	endfunction

	function void frame_in(logic [1:0] kind, logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
			logic [LEN_W-1:0] l, logic crc);
		bit [SEQ_W-1:0] from;
		if (l < MIN_FRAME_LEN || !crc || a > MAX_SEQ || (kind == KIND_DATA && s > MAX_SEQ)) begin
			nak_once();
			return;
		end
		while (outst != 0 && in_span(oldest, a, nts)) begin
			outst--;
			add_cmd(ACT_RELEASE, oldest, '0, '0, 1'b0, 1'b0, 1'b0);
			oldest = seq_next(oldest);
		end
		if (kind == KIND_DATA) begin
			if (s == exp_seq) begin
				add_cmd(ACT_DELIVER, '0, '0, (l > FRAME_OVERHEAD) ? l - FRAME_OVERHEAD : '0,
					1'b0, 1'b1, 1'b0);
				nak_out = 1'b0;
				exp_seq = seq_next(exp_seq);
			end else if (s > exp_seq) begin
				nak_once();
			end
		end else if (kind == KIND_NAK) begin
			from = seq_next(a);
			if (in_span(oldest, from, nts)) begin
				nts = from;
				resend_all();
			end
		end
	endfunction

	// one accepted transaction: work out every command it causes
	function void take_event(logic [2:0] req, logic [1:0] kind, logic [SEQ_W-1:0] s,
			logic [SEQ_W-1:0] a, logic [LEN_W-1:0] l, logic crc);
		bit en;
		link_cmd_t c;
		ev.delete();
		events++;
		case (req)
			REQ_PKT: begin
				if (outst < MAX_SEQ) begin
					outst++;
					push_data(nts);
					nts = seq_next(nts);
				end else begin
					full_hits++;
				end
			end
			REQ_LINK: ready = 1'b1;
			REQ_FRAME: frame_in(kind, s, a, l, crc);
			REQ_DATA_TMO: begin
				nts = oldest;
				resend_all();
			end
			REQ_ACK_TMO: send_ctrl(ACT_ACK);
			default: ;
		endcase
		if (ev.size() == 0)
			add_cmd(ACT_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
		en = (outst < MAX_SEQ) && ready;
		if (ev.size() > most_cmds)
			most_cmds = ev.size();
		for (int i = 0; i < ev.size(); i++) begin
			c = ev[i];
			c.net_en = en;
			c.last = (i == ev.size() - 1);
			pending.push_back(c);
		end
	endfunction

	function void check_cmd(logic [2:0] act, logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
			logic [LEN_W-1:0] d, logic sdt, logic sat, logic stat, logic ne, logic lst);
		link_cmd_t e;
		if (pending.size() == 0) begin
			strays++;
			if (strays + mismatches <= 10)
				$display("unexpected command: act=%0d seq=%0d ack=%0d len=%0d", act, s, a, d);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (act !== e.action || s !== e.seq || a !== e.ack || d !== e.len || sdt !== e.sdt
				|| sat !== e.sat || stat !== e.stat || ne !== e.net_en || lst !== e.last) begin
			mismatches++;
			if (strays + mismatches <= 10) begin
				$display("command %0d mismatch", checked);
				$display("  expected act=%0d seq=%0d ack=%0d len=%0d sdt=%b sat=%b stat=%b ne=%b last=%b",
					e.action, e.seq, e.ack, e.len, e.sdt, e.sat, e.stat, e.net_en, e.last);
				$display("  actual   act=%0d seq=%0d ack=%0d len=%0d sdt=%b sat=%b stat=%b ne=%b last=%b",
					act, s, a, d, sdt, sat, stat, ne, lst);
			end
		end
	endfunction
endclass

module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] req_type = '0;
	logic [1:0] frame_kind = '0;
	logic [SEQ_W-1:0] frame_seq = '0;
	logic [SEQ_W-1:0] peer_ack = '0;
	logic [LEN_W-1:0] frame_len = '0;
	logic crc_ok = 1'b0;
	logic busy;
	logic strobe;
	logic [2:0] action;
	logic [SEQ_W-1:0] seq_num;
	logic [SEQ_W-1:0] ack_num;
	logic [LEN_W-1:0] deliver_len;
	logic start_data_timer;
	logic ack_timer_start;
	logic ack_timer_stop;
	logic network_enable;
	logic last;

	link_cmd_model model = new;
	int idle_pct = 0;
	int fails;

	go_back_n_nak_link_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.frame_kind(frame_kind),
		.frame_seq(frame_seq),
		.peer_ack(peer_ack),
		.frame_len(frame_len),
		.crc_ok(crc_ok),
		.strobe(strobe),
		.action(action),
		.seq_num(seq_num),
		.ack_num(ack_num),
		.deliver_len(deliver_len),
		.start_data_timer(start_data_timer),
		.ack_timer_start(ack_timer_start),
		.ack_timer_stop(ack_timer_stop),
		.network_enable(network_enable),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (strobe === 1'b1)
			model.check_cmd(action, seq_num, ack_num, deliver_len, start_data_timer,
				ack_timer_start, ack_timer_stop, network_enable, last);
	end

	task automatic send_event(input logic [2:0] r, input logic [1:0] k,
			input logic [SEQ_W-1:0] s, input logic [SEQ_W-1:0] a,
			input logic [LEN_W-1:0] l, input logic c);
		// the sender sits out each cycle with the chance given by idle_pct
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= r;
		frame_kind <= k;
		frame_seq <= s;
		peer_ack <= a;
		frame_len <= l;
		crc_ok <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model.take_event(r, k, s, a, l, c);
	endtask

	// hold off the sender until every predicted command has come out
	task automatic drain_wait();
		start <= 1'b0;
		while (model.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_event();
		int pick;
		int off;
		logic [1:0] k;
		logic [SEQ_W-1:0] s;
		logic [SEQ_W-1:0] a;
		logic [LEN_W-1:0] l;
		pick = $urandom_range(0, 99);
		k = 2'($urandom);
		s = SEQ_W'($urandom);
		a = SEQ_W'($urandom);
		l = LEN_W'($urandom);
		if (pick < 25) begin
			send_event(REQ_PKT, k, s, a, l, 1'($urandom));
		end else if (pick < 35) begin
			send_event(REQ_LINK, k, s, a, l, 1'($urandom));
		end else if (pick < 65) begin
			// well-formed frame aimed at the current window
			case ($urandom_range(0, 3))
				0, 1: k = KIND_DATA;
				2: k = KIND_ACK;
				default: k = KIND_NAK;
			endcase
			if (k == KIND_DATA && $urandom_range(0, 3) != 0)
				s = model.exp_seq;
			l = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(5, 12))
				: LEN_W'($urandom_range(13, 511));
			if (model.outst != 0 && $urandom_range(0, 4) != 0) begin
				off = $urandom_range(0, int'(model.outst) - 1);
				a = model.oldest + SEQ_W'(off);
				if (k == KIND_NAK)
					a = a - 1'b1;
			end
			send_event(REQ_FRAME, k, s, a, l, 1'b1);
		end else if (pick < 73) begin
			send_event(REQ_DATA_TMO, k, s, a, l, 1'($urandom));
		end else if (pick < 80) begin
			send_event(REQ_ACK_TMO, k, s, a, l, 1'($urandom));
		end else if (pick < 95) begin
			send_event(REQ_FRAME, k, s, a, l, 1'($urandom));
		end else begin
			send_event(3'($urandom), k, s, a, l, 1'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 19;
		send_event(REQ_ACK_TMO, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_PKT, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_LINK, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_PKT, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_PKT, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_PKT, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		// in-order data, longest frame, releases frame 0
		send_event(REQ_FRAME, KIND_DATA, 5'd0, 5'd0, 9'd511, 1'b1);
		// delivered length floors at zero
		send_event(REQ_FRAME, KIND_DATA, 5'd1, 5'd31, 9'd7, 1'b1);
		send_event(REQ_FRAME, KIND_DATA, 5'd2, 5'd31, 9'd5, 1'b1);
		// short frame, then a crc failure while the nak is still out
		send_event(REQ_FRAME, KIND_DATA, 5'd3, 5'd31, 9'd4, 1'b1);
		send_event(REQ_FRAME, KIND_DATA, 5'd3, 5'd31, 9'd100, 1'b0);
		send_event(REQ_FRAME, KIND_DATA, 5'd3, 5'd31, 9'd8, 1'b1);
		// ahead of expected gives a nak, behind is dropped
		send_event(REQ_FRAME, KIND_DATA, 5'd10, 5'd31, 9'd64, 1'b1);
		send_event(REQ_FRAME, KIND_DATA, 5'd1, 5'd31, 9'd64, 1'b1);
		send_event(REQ_FRAME, KIND_ACK, 5'd0, 5'd2, 9'd5, 1'b1);
		send_event(REQ_FRAME, KIND_NAK, 5'd0, 5'd2, 9'd5, 1'b1);
		send_event(REQ_DATA_TMO, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_FRAME, 2'd3, 5'd31, 5'd3, 9'd511, 1'b1);
		send_event(3'd5, 2'd3, 5'd31, 5'd31, 9'd511, 1'b1);
		send_event(3'd6, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(3'd7, 2'd3, 5'd31, 5'd31, 9'd511, 1'b1);
		send_event(REQ_FRAME, KIND_DATA, 5'd31, 5'd31, 9'd511, 1'b0);
		send_event(REQ_FRAME, KIND_NAK, 5'd0, 5'd0, 9'd0, 1'b1);
		drain_wait();
		repeat (20) random_event();
		drain_wait();

		idle_pct = 80;
		repeat (20) random_event();
		drain_wait();

		// no idling: fill the window, overrun it, resend it all, then ack it all at once
		idle_pct = 0;
		send_event(REQ_LINK, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		while (model.outst < MAX_SEQ)
			send_event(REQ_PKT, 2'($urandom), SEQ_W'($urandom), SEQ_W'($urandom),
				LEN_W'($urandom), 1'($urandom));
		send_event(REQ_PKT, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_PKT, KIND_NAK, 5'd31, 5'd31, 9'd511, 1'b1);
		send_event(REQ_DATA_TMO, KIND_DATA, 5'd0, 5'd0, 9'd0, 1'b0);
		send_event(REQ_FRAME, KIND_DATA, model.exp_seq, model.nts - 1'b1,
			LEN_W'($urandom_range(5, 511)), 1'b1);
		repeat (20) random_event();
		drain_wait();
		repeat (80) @(posedge clk);

		$display("covered %0d link events, %0d commands checked, up to %0d commands per event",
			model.events, model.checked, model.most_cmds);
		$display("window-full packet offers %0d, sender idle mixes of 19, 80 and 0 percent",
			model.full_hits);
		fails = model.mismatches + model.strays + model.pending.size();
		if (fails == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
